[hw/rtl/osf_pkg.sv]
// Shared constants and types for the OSC 1 sequence filter.
package osf_pkg;

   localparam int HOLD_DEPTH = 64;
   localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
   localparam int ADDR_W     = $clog2(HOLD_DEPTH);
   localparam int CMD_W      = 30;

   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_BEL      = 8'h07;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_BSLASH   = 8'h5C;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;

   localparam logic [CMD_W-1:0] CMD_LIMIT = CMD_W'(99999999);

   // parser -> hold buffer
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              start;
      logic [CNT_W-1:0]  len;
   } osf_hold_cmd_type;

   // hold buffer -> parser / output stage
   typedef struct packed {
      logic       busy;
      logic       rd_vld;
      logic [7:0] rd_byte;
      logic       rd_last;
   } osf_hold_stat_type;

endpackage

[hw/rtl/osf_hold_buf.sv]
// Hold buffer: sequence byte memory and replay read sequencer.
module osf_hold_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  osf_pkg::osf_hold_cmd_type hold_cmd,
   input  logic                      rd_take,
   output osf_pkg::osf_hold_stat_type hold_stat
);
   import osf_pkg::*;

   logic [7:0]       mem [HOLD_DEPTH];
   logic             rp_active_ff, rp_active_in;
   logic [CNT_W-1:0] rp_addr_ff, rp_addr_in;
   logic [CNT_W-1:0] rp_len_ff, rp_len_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [7:0]       rd_byte_ff;
   logic             rd_last_ff;
   logic             issue;
   logic             issue_last;

   assign issue      = rp_active_ff && (!rd_vld_ff || rd_take);
   assign issue_last = (rp_addr_ff + CNT_W'(1)) == rp_len_ff;

   always_comb begin
      rp_active_in = rp_active_ff;
      rp_addr_in   = rp_addr_ff;
      rp_len_in    = rp_len_ff;
      rd_vld_in    = rd_vld_ff;
      if (rd_take) begin
         rd_vld_in = 1'b0;
      end
      if (issue) begin
         rd_vld_in  = 1'b1;
         rp_addr_in = rp_addr_ff + CNT_W'(1);
         if (issue_last) begin
            rp_active_in = 1'b0;
         end
      end
      if (hold_cmd.start) begin
         rp_active_in = 1'b1;
         rp_addr_in   = '0;
         rp_len_in    = hold_cmd.len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_active_ff <= 1'b0;
         rp_addr_ff   <= '0;
         rp_len_ff    <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         rp_active_ff <= rp_active_in;
         rp_addr_ff   <= rp_addr_in;
         rp_len_ff    <= rp_len_in;
         rd_vld_ff    <= rd_vld_in;
      end
   end

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (hold_cmd.wr_en) begin
         mem[hold_cmd.wr_addr] <= hold_cmd.wr_data;
      end
      if (issue) begin
         rd_byte_ff <= mem[rp_addr_ff[ADDR_W-1:0]];
         rd_last_ff <= issue_last;
      end
   end

   assign hold_stat.busy    = rp_active_ff || rd_vld_ff;
   assign hold_stat.rd_vld  = rd_vld_ff;
   assign hold_stat.rd_byte = rd_byte_ff;
   assign hold_stat.rd_last = rd_last_ff;

endmodule

[hw/rtl/osc1_sequence_filter_core.sv]
// Top level: OSC 1 escape sequence filter for a terminal output byte stream.
//
//   channel | ports                                  | beat
//   --------+----------------------------------------+-------------------------------
//   input   | req_valid req_ready req_in_byte        | one stream byte
//   result  | rsp_valid rsp_ready rsp_out_byte       | one forwarded byte, last flag
//           | rsp_last_of_run                        | on final beat for an input
//
// Plain text: one beat in, one beat out, every cycle while the result side takes beats.
// Sequence bytes (from ESC on) go to memory at one beat a cycle unless stalled, no output.
// On replay of n held bytes the input stalls until the last byte is taken: the single
// registered read port of the hold memory gives one byte a cycle while output is free.
// Reset is synchronous and clears the parser and output valid; the hold memory
// is not cleared, only entries written since the ESC are read back.
// A stalled result holds in the output register; plain input still moves when
// that register is taken in the same cycle.
module osc1_sequence_filter_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);
   import osf_pkg::*;

   typedef enum logic [1:0] {
      MODE_NORMAL,
      MODE_ESC,
      MODE_OSC
   } mode_type;

   // parser state
   mode_type         mode_ff, mode_in;
   logic             esc_pend_ff, esc_pend_in;
   logic             decided_ff, decided_in;
   logic             drop_ff, drop_in;
   logic [CMD_W-1:0] cmd_val_ff, cmd_val_in;
   logic             digit_ff, digit_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in;

   osf_hold_cmd_type  hold_cmd;
   osf_hold_stat_type hold_stat;

   logic       out_free;
   logic       accept;
   logic       rd_take;
   logic       pass;
   logic       seq_clr;
   logic       seq_done;
   logic       is_digit;
   logic [3:0] dig;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !hold_stat.busy && out_free;
   assign accept    = req_valid && req_ready;
   assign rd_take   = hold_stat.rd_vld && out_free;
   assign is_digit  = (req_in_byte >= CH_ZERO) && (req_in_byte <= CH_NINE);
   // ASCII digits carry their value in the low nibble
   assign dig       = req_in_byte[3:0];

   // parser: one input byte per accepted beat
   always_comb begin
      mode_in     = mode_ff;
      esc_pend_in = esc_pend_ff;
      decided_in  = decided_ff;
      drop_in     = drop_ff;
      cmd_val_in  = cmd_val_ff;
      digit_in    = digit_ff;
      cnt_in      = cnt_ff;
      pass        = 1'b0;
      seq_clr     = 1'b0;
      seq_done    = 1'b0;
      hold_cmd    = '0;
      hold_cmd.wr_data = req_in_byte;

      if (accept) begin
         case (mode_ff)
            MODE_NORMAL: begin
               if (req_in_byte == CH_ESC) begin
                  // fresh sequence: ESC goes to entry zero
                  mode_in          = MODE_ESC;
                  esc_pend_in      = 1'b0;
                  decided_in       = 1'b0;
                  drop_in          = 1'b0;
                  cmd_val_in       = '0;
                  digit_in         = 1'b0;
                  hold_cmd.wr_en   = 1'b1;
                  hold_cmd.wr_addr = '0;
                  cnt_in           = CNT_W'(1);
               end else begin
                  pass = 1'b1;
               end
            end

            MODE_ESC: begin
               if (cnt_ff >= CNT_W'(HOLD_DEPTH)) begin
                  drop_in = 1'b1;
               end else begin
                  hold_cmd.wr_en   = 1'b1;
                  hold_cmd.wr_addr = cnt_ff[ADDR_W-1:0];
                  cnt_in           = cnt_ff + CNT_W'(1);
               end
               if (req_in_byte == CH_RBRACKET) begin
                  mode_in = MODE_OSC;
               end else begin
                  hold_cmd.start = 1'b1;
                  hold_cmd.len   = cnt_in;
                  mode_in        = MODE_NORMAL;
                  seq_clr        = 1'b1;
               end
            end

            MODE_OSC: begin
               if (cnt_ff >= CNT_W'(HOLD_DEPTH)) begin
                  drop_in = 1'b1;
               end else begin
                  hold_cmd.wr_en   = 1'b1;
                  hold_cmd.wr_addr = cnt_ff[ADDR_W-1:0];
                  cnt_in           = cnt_ff + CNT_W'(1);
               end
               // ESC backslash terminator
               if (esc_pend_ff) begin
                  esc_pend_in = 1'b0;
                  if (req_in_byte == CH_BSLASH) begin
                     seq_done = 1'b1;
                  end
               end
               if (!seq_done) begin
                  if (!decided_ff) begin
                     if (is_digit) begin
                        if (cmd_val_ff <= CMD_LIMIT) begin
                           cmd_val_in = (cmd_val_ff << 3) + (cmd_val_ff << 1)
                                      + CMD_W'(dig);
                        end
                        digit_in = 1'b1;
                     end else if (req_in_byte == CH_SEMI) begin
                        decided_in = 1'b1;
                        drop_in    = digit_ff && (cmd_val_ff == CMD_W'(1));
                     end else begin
                        decided_in = 1'b1;
                        drop_in    = 1'b0;
                     end
                  end
                  if (req_in_byte == CH_BEL) begin
                     seq_done = 1'b1;
                  end else if (req_in_byte == CH_ESC) begin
                     esc_pend_in = 1'b1;
                  end
               end
               if (seq_done) begin
                  hold_cmd.start = !drop_in;
                  hold_cmd.len   = cnt_in;
                  mode_in        = MODE_NORMAL;
                  seq_clr        = 1'b1;
               end
            end

            default: begin
               mode_in = MODE_NORMAL;
               seq_clr = 1'b1;
            end
         endcase
      end

      if (seq_clr) begin
         esc_pend_in = 1'b0;
         decided_in  = 1'b0;
         drop_in     = 1'b0;
         cmd_val_in  = '0;
         digit_in    = 1'b0;
         cnt_in      = '0;
      end
   end

   // output register: plain byte or replayed byte, never both in one cycle
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (pass) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = req_in_byte;
         rsp_last_in  = 1'b1;
      end else if (rd_take) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = hold_stat.rd_byte;
         rsp_last_in  = hold_stat.rd_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         esc_pend_ff  <= 1'b0;
         decided_ff   <= 1'b0;
         drop_ff      <= 1'b0;
         cmd_val_ff   <= '0;
         digit_ff     <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         esc_pend_ff  <= esc_pend_in;
         decided_ff   <= decided_in;
         drop_ff      <= drop_in;
         cmd_val_ff   <= cmd_val_in;
         digit_ff     <= digit_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_byte_ff  <= rsp_byte_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   osf_hold_buf u_hold (
      .clock     (clock),
      .reset     (reset),
      .hold_cmd  (hold_cmd),
      .rd_take   (rd_take),
      .hold_stat (hold_stat)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

[hw/rtl/osf_core_checker.sv]
// Port-level checker for the sequence filter core, with its bind.
module osf_core_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_in_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run
);

   // a waiting input beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_in_byte))
      else $error("input beat changed while waiting");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                  && $stable(rsp_last_of_run))
      else $error("result beat changed while stalled");

   // input only taken when the output register can take a beat
   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid || rsp_ready)
      else $error("input ready with output register blocked");

   // mid-replay: input must stay stalled until the last beat
   a_replay_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> !req_ready)
      else $error("input ready during replay");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind osc1_sequence_filter_core osf_core_checker u_osf_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_in_byte     (req_in_byte),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_last_of_run (rsp_last_of_run)
);

[tb/tb_top.sv]
// Self-checking testbench for the OSC 1 sequence filter core.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import osf_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int CYCLE_LIMIT = 400000;  // far above the slowest legal run
   localparam int DRAIN_WAIT  = 100;     // a replay holds at most HOLD_DEPTH bytes
   localparam int RANDOM_BEATS = 75;
   localparam int MAX_REPORTS = 10;

   // ------------------------------------------------------------------
   // Scoreboard: tracks the filter's parser state and keeps the queue of
   // bytes that should come out, in stream order, with their last flag.
   // ------------------------------------------------------------------
   class osf_scoreboard;
      typedef enum logic [1:0] {ST_NORMAL, ST_ESC, ST_OSC, ST_UNUSED} parse_state_type;

      parse_state_type  mode;
      logic             esc_seen;
      logic             cmd_settled;
      logic             discard;
      logic [CMD_W-1:0] cmd_num;
      logic             have_digit;
      int               held_n;
      logic [7:0]       held [HOLD_DEPTH];

      logic [7:0] fwd_bytes [$];
      logic       fwd_last  [$];

      int beats_in, beats_out, errors;
      int seq_dropped, seq_replayed, overflow_bytes;

      function new();
         mode = ST_NORMAL;
         clear_seq();
         foreach (held[i]) held[i] = 8'h00;
      endfunction

      function void clear_seq();
         esc_seen    = 1'b0;
         cmd_settled = 1'b0;
         discard     = 1'b0;
         cmd_num     = '0;
         have_digit  = 1'b0;
         held_n      = 0;
      endfunction

      function void push(logic [7:0] b, logic last);
         fwd_bytes.push_back(b);
         fwd_last.push_back(last);
      endfunction

      // a byte that finds the buffer full is lost and marks the sequence
      function void hold(logic [7:0] b);
         if (held_n >= HOLD_DEPTH) begin
            discard = 1'b1;
            overflow_bytes++;
         end else begin
            held[held_n] = b;
            held_n++;
         end
      endfunction

      function void replay();
         for (int i = 0; i < held_n; i++)
            push(held[i], (i == held_n - 1));
         if (held_n > 0) seq_replayed++;
      endfunction

      // terminator seen: replay unless marked, then back to plain text
      function void close_seq();
         if (!discard) replay();
         else seq_dropped++;
         mode = ST_NORMAL;
         clear_seq();
      endfunction

      function void note_input(logic [7:0] b);
         logic terminated;
         terminated = 1'b0;
         beats_in++;
         case (mode)
            ST_NORMAL: begin
               if (b == CH_ESC) begin
                  mode = ST_ESC;
                  clear_seq();
                  hold(b);
               end else begin
                  push(b, 1'b1);
               end
            end
            ST_ESC: begin
               hold(b);
               if (b == CH_RBRACKET) begin
                  mode = ST_OSC;
               end else begin
                  replay();
                  mode = ST_NORMAL;
                  clear_seq();
               end
            end
            ST_OSC: begin
               hold(b);
               if (esc_seen) begin
                  esc_seen = 1'b0;
                  if (b == CH_BSLASH) begin
                     close_seq();
                     terminated = 1'b1;
                  end
               end
               if (!terminated) begin
                  if (!cmd_settled) begin
                     if (b >= CH_ZERO && b <= CH_NINE) begin
                        // saturate: digits past the limit are ignored
                        if (cmd_num <= CMD_LIMIT)
                           cmd_num = CMD_W'(cmd_num * 10 + (b - CH_ZERO));
                        have_digit = 1'b1;
                     end else if (b == CH_SEMI) begin
                        cmd_settled = 1'b1;
                        discard = have_digit && (cmd_num == CMD_W'(1));
                     end else begin
                        // any other non-digit settles as kept, even BEL
                        cmd_settled = 1'b1;
                        discard = 1'b0;
                     end
                  end
                  if (b == CH_BEL) close_seq();
                  else if (b == CH_ESC) esc_seen = 1'b1;
               end
            end
            default: begin
               mode = ST_NORMAL;
               clear_seq();
            end
         endcase
      endfunction

      function void check_result(logic [7:0] b, logic last);
         logic [7:0] want_b;
         logic       want_last;
         beats_out++;
         if (fwd_bytes.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("[%0t] unexpected output beat: byte %02h last %0b", $time, b, last);
            return;
         end
         want_b    = fwd_bytes.pop_front();
         want_last = fwd_last.pop_front();
         if (b !== want_b || last !== want_last) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("[%0t] output beat %0d: byte %02h last %0b, expected %02h last %0b",
                        $time, beats_out, b, last, want_b, want_last);
         end
      endfunction

      function int pending();
         return fwd_bytes.size();
      endfunction

      function void drain_check();
         if (fwd_bytes.size() != 0) begin
            errors += fwd_bytes.size();
            $display("%0d expected output beats never arrived", fwd_bytes.size());
         end
      endfunction
   endclass

   // ------------------------------------------------------------------
   // DUT and its signals
   // ------------------------------------------------------------------
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;

   osc1_sequence_filter_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   osf_scoreboard sb = new();

   int  cycles = 0;
   int  sent = 0;
   logic no_idle = 1'b0;   // set for a stretch of back-to-back traffic

   always #HALF_PERIOD clock = ~clock;

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d output beats outstanding",
                  cycles, sb.pending());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Result side back-pressure: ready drops in about a third of cycles,
   // except during the no-idle stretch.
   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= 34);
   end

   // Both channels are sampled on the same edge. Input is noted first so
   // the expectation always exists before any result it could produce.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_input(req_in_byte);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_out_byte, rsp_last_of_run);
      end
   end

   // ------------------------------------------------------------------
   // Stimulus tasks. All are entered just after a rising edge.
   // ------------------------------------------------------------------

   // One input beat. Each idle cycle lowers valid first; otherwise valid
   // stays high from the previous beat and only the data changes.
   task automatic put_byte(input logic [7:0] b);
      while (!no_idle && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   // ESC ] body, then BEL or ESC backslash
   task automatic put_osc(input string body, input logic st_term);
      put_byte(CH_ESC);
      put_byte(CH_RBRACKET);
      put_text(body);
      if (st_term) begin
         put_byte(CH_ESC);
         put_byte(CH_BSLASH);
      end else begin
         put_byte(CH_BEL);
      end
   endtask

   task automatic put_repeat(input logic [7:0] b, input int n);
      repeat (n) put_byte(b);
   endtask

   // payload byte that neither terminates nor starts an escape
   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do b = 8'($urandom); while (b == CH_ESC || b == CH_BEL);
      return b;
   endfunction

   // Well-formed OSC with random command and content; now and then broken
   // (no terminator) or long enough to overrun the hold buffer.
   task automatic random_osc();
      int len;
      int pick;
      put_byte(CH_ESC);
      put_byte(CH_RBRACKET);
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2: put_text("1");
         3:       put_text("2");
         4:       put_text("0");
         5:       put_text("01");
         6:       repeat ($urandom_range(1, 12)) put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
         7:       ;
         8:       put_byte(text_byte());
         default: put_text("11");
      endcase
      if ($urandom_range(0, 99) < 85) put_byte(CH_SEMI);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 12);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            put_byte(CH_ESC);       // ESC, a string terminator only if a backslash follows
            put_byte(text_byte());
         end else begin
            put_byte(text_byte());
         end
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         put_byte(CH_BEL);
      end else if (pick < 9) begin
         put_byte(CH_ESC);
         put_byte(CH_BSLASH);
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int base;
      int pick;
      logic [7:0] nb;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      put_byte(8'h00);
      put_byte(8'hFF);
      put_text("Hi");
      put_byte(CH_ESC); put_text("X");          // plain escape, replayed at once
      put_byte(CH_ESC); put_byte(CH_ESC);       // ESC ESC, replayed as a pair
      put_osc("1;title", 1'b0);                 // OSC 1, BEL: dropped
      put_osc("1;t", 1'b1);                     // OSC 1, ESC backslash: dropped
      put_osc("2;win", 1'b0);                   // other commands pass
      put_osc("0;x", 1'b1);
      put_osc("01;x", 1'b0);                    // leading zero still means 1
      put_osc(";x", 1'b0);                      // no digits: kept
      put_osc("1", 1'b0);                       // BEL before ';' settles as kept
      put_osc("100000000001;x", 1'b0);          // saturated command number
      put_osc("", 1'b1);                        // ESC before any command byte
      put_byte(CH_ESC); put_text("]1;a");       // stray ESC inside a dropped OSC
      put_byte(CH_ESC); put_text("b"); put_byte(CH_BEL);
      put_byte(CH_ESC); put_text("]2;");        // stray ESC inside a kept OSC
      put_byte(CH_ESC); put_text("X"); put_byte(CH_BEL);
      put_byte(CH_ESC); put_text("]1;");        // extreme payload, dropped
      put_byte(8'h00); put_byte(8'hFF); put_byte(CH_BEL);
      // overrun, then a ';' that clears the mark; the BEL overruns too: dropped
      put_byte(CH_ESC); put_byte(CH_RBRACKET);
      put_repeat("1", 70); put_byte(CH_SEMI); put_byte(CH_BEL);
      // overrun after the command is settled: mark stays, nothing out
      put_osc("2;", 1'b0);
      put_byte(CH_ESC); put_text("]2;"); put_repeat("a", 70); put_byte(CH_BEL);
      // overrun where the late decision is command 1: dropped
      put_byte(CH_ESC); put_byte(CH_RBRACKET);
      put_repeat("0", 69); put_text("1;"); put_byte(CH_BEL);

      // --- random ---
      base = sent;
      while (sent < base + RANDOM_BEATS) begin
         no_idle = (sent - base >= 15) && (sent - base < 55);
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            repeat ($urandom_range(1, 8)) put_byte(text_byte());
         end else if (pick < 75) begin
            random_osc();
         end else if (pick < 90) begin
            put_byte(CH_ESC);
            nb = text_byte();
            put_byte(nb == CH_RBRACKET ? 8'h41 : nb);
         end else begin
            repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
         end
      end
      no_idle = 1'b0;
      // close any sequence the noise left open, so its bytes come out unless it is dropped
      put_byte(CH_BEL);
      put_text("z");
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      sb.drain_check();

      $display("%0d bytes in, %0d bytes out over %0d cycles", sb.beats_in, sb.beats_out, cycles);
      $display("%0d sequences replayed, %0d discarded, %0d bytes lost to a full buffer",
               sb.seq_replayed, sb.seq_dropped, sb.overflow_bytes);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/osf_pkg.sv
hw/rtl/osf_hold_buf.sv
hw/rtl/osc1_sequence_filter_core.sv
hw/rtl/osf_core_checker.sv
tb/tb_top.sv
